@@ hdl/block_rms_ema_meter_top_assert.svh @@
// Assertion macros for the RMS meter.
`ifndef BLOCK_RMS_EMA_METER_TOP_ASSERT_SVH
`define BLOCK_RMS_EMA_METER_TOP_ASSERT_SVH
`ifndef SYNTH
`define BRM_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");
`define BRM_ASSERT_NR(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) else $error("assertion failed");
`else
`define BRM_ASSERT(label, clk_s, rst_s, prop)
`define BRM_ASSERT_NR(label, clk_s, prop)
`endif
`endif

@@ hdl/brm_pkg.sv @@
package brm_pkg;
  localparam int MaxBlock = 4096;
  localparam int SumW = 43;
  // The count port carries MaxBlock itself and values above it.
  localparam int CntW = $clog2(MaxBlock) + 1;
  localparam int RmsW = 16;
  localparam int AccW = 32;
  localparam int AlphaW = 16;
  localparam logic [RmsW-1:0] RmsFull = 16'd32768;
  localparam logic CmdRecord = 1'b0;
  localparam logic CmdClear = 1'b1;
endpackage

@@ hdl/brm_lane.sv @@
// One lane: restoring division of the sum by the count, one quotient bit per
// cycle, then a restoring square root, one result bit per cycle.
module brm_lane (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [brm_pkg::SumW-1:0] sum_sq,
  input  logic [brm_pkg::CntW-1:0] count,
  output logic done,
  output logic [brm_pkg::RmsW-1:0] rms
);
  import brm_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSqrt = 2'd2;

  logic [1:0] state;
  logic [5:0] step;
  logic [SumW-1:0] quo;
  logic [CntW:0] rem;
  logic [CntW-1:0] div;
  logic [SumW:0] rad;
  logic [SumW+1:0] sq_rem;
  logic [22:0] root;
  logic [CntW:0] rem_sh;
  logic [SumW+1:0] sq_sh;
  logic [SumW+1:0] trial;

  assign rem_sh = {rem[CntW-1:0], quo[SumW-1]};
  assign sq_sh = {sq_rem[SumW-1:0], rad[SumW -: 2]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        StIdle: begin
          if (start) begin
            if (count == '0 || sum_sq == '0) begin
              done <= 1'b1;
            end else begin
              quo <= sum_sq;
              div <= count;
              rem <= '0;
              step <= 6'(SumW - 1);
              state <= StDiv;
            end
          end
        end
        StDiv: begin
          if (rem_sh >= {1'b0, div}) begin
            rem <= rem_sh - {1'b0, div};
            quo <= {quo[SumW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[SumW-2:0], 1'b0};
          end
          if (step == '0) begin
            state <= StSqrt;
            step <= 6'd22;
          end else begin
            step <= step - 6'd1;
          end
        end
        StSqrt: begin
          if (step == 6'd22) begin
            // The radicand is padded to an even width: 22 bit pairs.
            rad <= {1'b0, quo};
            sq_rem <= '0;
            root <= '0;
            step <= 6'd21;
          end else begin
            rad <= {rad[SumW-2:0], 2'b00};
            if (sq_sh >= trial) begin
              sq_rem <= sq_sh - trial;
              root <= {root[21:0], 1'b1};
            end else begin
              sq_rem <= sq_sh;
              root <= {root[21:0], 1'b0};
            end
            if (step == '0) begin
              state <= StIdle;
              done <= 1'b1;
            end else begin
              step <= step - 6'd1;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Final root bit is resolved in the same edge as done; saturate the result.
  logic [22:0] root_fin;
  assign root_fin = (sq_sh >= trial) ? {root[21:0], 1'b1} : {root[21:0], 1'b0};
  always_ff @(posedge clk) begin
    if (state == StIdle && start && (count == '0 || sum_sq == '0)) begin
      rms <= '0;
    end else if (state == StSqrt && step == '0) begin
      rms <= (root_fin > 23'(RmsFull)) ? RmsFull : root_fin[RmsW-1:0];
    end
  end
endmodule

@@ hdl/brm_merge.sv @@
// Combines the lane results: counter, held RMS values and the two averages.
module brm_merge (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic update,
  input  logic [brm_pkg::AlphaW-1:0] alpha,
  input  logic [brm_pkg::RmsW-1:0] in_rms,
  input  logic [brm_pkg::RmsW-1:0] left_rms,
  input  logic [brm_pkg::RmsW-1:0] right_rms,
  output logic done,
  output logic [31:0] count,
  output logic [brm_pkg::RmsW-1:0] hold_in,
  output logic [brm_pkg::RmsW-1:0] hold_left,
  output logic [brm_pkg::RmsW-1:0] hold_right,
  output logic [brm_pkg::RmsW-1:0] smooth_in,
  output logic [brm_pkg::RmsW-1:0] smooth_out
);
  import brm_pkg::*;

  logic [AccW-1:0] acc_in, acc_out, x_in, x_out;
  logic [16:0] w_old;
  logic [1:0] phase;
  logic [48:0] p_old, p_new;
  logic [AccW-1:0] cur_acc, cur_x;
  logic seed;
  logic [32:0] sum_in, sum_out;

  assign w_old = 17'h10000 - {1'b0, alpha};
  assign cur_acc = (phase == 2'd1) ? acc_in : acc_out;
  assign cur_x = (phase == 2'd1) ? x_in : x_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done <= 1'b0;
      count <= '0;
      hold_in <= '0; hold_left <= '0; hold_right <= '0;
      acc_in <= '0; acc_out <= '0;
    end else begin
      done <= 1'b0;
      if (clear) begin
        count <= '0;
        hold_in <= '0; hold_left <= '0; hold_right <= '0;
        acc_in <= '0; acc_out <= '0;
        done <= 1'b1;
      end else if (update) begin
        hold_in <= in_rms; hold_left <= left_rms; hold_right <= right_rms;
        x_in <= {in_rms, 16'h0};
        x_out <= AccW'({17'(left_rms) + 17'(right_rms), 15'h0});
        count <= count + 32'd1;
        seed <= (count + 32'd1) == 32'd1;
        phase <= 2'd1;
      end else if (phase == 2'd1 || phase == 2'd2) begin
        // Multiply stage; a seeded average takes x as its old value.
        p_old <= (seed ? cur_x : cur_acc) * w_old;
        p_new <= cur_x * alpha;
        phase <= phase + 2'd1;
        if (phase == 2'd2) begin
          acc_in <= sum_in[AccW-1:0];
        end
      end else if (phase == 2'd3) begin
        acc_out <= sum_out[AccW-1:0];
        phase <= '0;
        done <= 1'b1;
      end
    end
  end

  logic [49:0] tot;
  assign tot = 50'(p_old) + 50'(p_new) + 50'd32768;
  assign sum_in = tot[48:16];
  assign sum_out = tot[48:16];

  logic [32:0] r_in, r_out;
  assign r_in = 33'(acc_in) + 33'd32768;
  assign r_out = 33'(acc_out) + 33'd32768;
  assign smooth_in = r_in[31:16];
  assign smooth_out = r_out[31:16];
endmodule

@@ hdl/block_rms_ema_meter_top.sv @@
// RMS level meter with exponential smoothing.
// Input channel: in_valid/in_stall with cmd, three sums of squares and the
// sample count. cmd set clears the counter, held RMS values and averages.
// Output channel: out_valid/out_stall with one snapshot per accepted item.
// ema_alpha must be written by cfg_we/cfg_data only while the block is idle;
// the block itself does not enforce this. Three lanes run side by side, one
// per sum: each divides by the count at one bit per cycle, loads the radicand
// and takes the root at one bit per cycle. The lane results are collected in a
// register, the merge stage updates the averages and the output register holds
// the snapshot. A clear goes straight to the merge stage, and an item whose
// count or all three sums are zero skips the division and the root.
// One item is in work at a time; in_stall is high from transfer until the
// result has been transferred out, and the next item can be transferred in the
// cycle after that. While out_stall is high the result holds.
// Reset clears the control state, counter, held RMS values and averages, sets
// ema_alpha to 6554 and leaves the block idle.
module block_rms_ema_meter_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [brm_pkg::AlphaW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic cmd,
  input  logic [brm_pkg::SumW-1:0] in_sum_sq,
  input  logic [brm_pkg::SumW-1:0] left_sum_sq,
  input  logic [brm_pkg::SumW-1:0] right_sum_sq,
  input  logic [brm_pkg::CntW-1:0] sample_count,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] block_count,
  output logic [brm_pkg::RmsW-1:0] last_in_rms,
  output logic [brm_pkg::RmsW-1:0] last_left_rms,
  output logic [brm_pkg::RmsW-1:0] last_right_rms,
  output logic [brm_pkg::RmsW-1:0] smooth_in_rms,
  output logic [brm_pkg::RmsW-1:0] smooth_out_rms
);
  import brm_pkg::*;
  `include "block_rms_ema_meter_top_assert.svh"

  logic [AlphaW-1:0] alpha;
  logic busy, start, clear;
  logic [2:0] lane_done, lane_seen;
  logic [RmsW-1:0] r_in, r_left, r_right;
  logic merge_done, all_lanes;
  logic [RmsW-1:0] rms_in_q, rms_left_q, rms_right_q;
  logic [RmsW-1:0] h_in, h_l, h_r, s_in, s_out;
  logic [31:0] cnt;

  assign in_stall = busy;
  assign start = in_valid && !busy && cmd == CmdRecord;
  assign clear = in_valid && !busy && cmd == CmdClear;

  always_ff @(posedge clk) begin
    if (rst) alpha <= 16'd6554;
    else if (cfg_we) alpha <= cfg_data;
  end

  brm_lane u_in (.clk, .rst, .start, .sum_sq(in_sum_sq), .count(sample_count),
    .done(lane_done[0]), .rms(r_in));
  brm_lane u_left (.clk, .rst, .start, .sum_sq(left_sum_sq), .count(sample_count),
    .done(lane_done[1]), .rms(r_left));
  brm_lane u_right (.clk, .rst, .start, .sum_sq(right_sum_sq), .count(sample_count),
    .done(lane_done[2]), .rms(r_right));

  // A lane with a zero sum finishes early, so collect the done flags.
  assign all_lanes = (lane_seen | lane_done) == 3'b111 && lane_seen != 3'b111;

  always_ff @(posedge clk) begin
    if (rst || start) lane_seen <= '0;
    else if (all_lanes) lane_seen <= 3'b111;
    else lane_seen <= lane_seen | lane_done;
    if (lane_done[0]) rms_in_q <= r_in;
    if (lane_done[1]) rms_left_q <= r_left;
    if (lane_done[2]) rms_right_q <= r_right;
  end

  logic go_merge;
  logic all_prev;
  always_ff @(posedge clk) begin
    if (rst) all_prev <= 1'b0;
    else all_prev <= all_lanes && busy;
  end
  assign go_merge = all_prev;

  brm_merge u_merge (.clk, .rst, .clear, .update(go_merge), .alpha,
    .in_rms(rms_in_q), .left_rms(rms_left_q), .right_rms(rms_right_q),
    .done(merge_done), .count(cnt), .hold_in(h_in), .hold_left(h_l),
    .hold_right(h_r), .smooth_in(s_in), .smooth_out(s_out));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      block_count <= '0;
      last_in_rms <= '0;
      last_left_rms <= '0;
      last_right_rms <= '0;
      smooth_in_rms <= '0;
      smooth_out_rms <= '0;
    end else begin
      if (in_valid && !busy) busy <= 1'b1;
      if (merge_done) begin
        out_valid <= 1'b1;
        block_count <= cnt;
        last_in_rms <= h_in;
        last_left_rms <= h_l;
        last_right_rms <= h_r;
        smooth_in_rms <= s_in;
        smooth_out_rms <= s_out;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
        busy <= 1'b0;
      end
    end
  end

  `BRM_ASSERT(a_no_accept_busy, clk, rst, out_valid |-> in_stall)
  `BRM_ASSERT(a_result_needs_item, clk, rst, merge_done |-> busy)
  `BRM_ASSERT(a_clear_zero, clk, rst, $past(clear) |=> block_count == 32'd0)
  `BRM_ASSERT(a_hold_out, clk, rst, out_valid && out_stall |=> out_valid)
endmodule

@@ test/tb.sv @@
module tb;
  import brm_pkg::*;

  typedef struct {
    logic            cmd;
    logic [SumW-1:0] in_sq;
    logic [SumW-1:0] left_sq;
    logic [SumW-1:0] right_sq;
    logic [CntW-1:0] count;
  } block_item_t;

  typedef struct {
    logic [31:0]     blocks;
    logic [RmsW-1:0] in_rms;
    logic [RmsW-1:0] left_rms;
    logic [RmsW-1:0] right_rms;
    logic [RmsW-1:0] smooth_in;
    logic [RmsW-1:0] smooth_out;
  } meter_snap_t;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [AlphaW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CmdRecord;
  logic [SumW-1:0] in_sum_sq = '0;
  logic [SumW-1:0] left_sum_sq = '0;
  logic [SumW-1:0] right_sum_sq = '0;
  logic [CntW-1:0] sample_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] block_count;
  logic [RmsW-1:0] last_in_rms;
  logic [RmsW-1:0] last_left_rms;
  logic [RmsW-1:0] last_right_rms;
  logic [RmsW-1:0] smooth_in_rms;
  logic [RmsW-1:0] smooth_out_rms;

  block_item_t pending_blocks[$];
  meter_snap_t expected_snaps[$];
  bit          item_taken = 0;
  bit          quiet = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          errors = 0;

  // Meter state as predicted.
  logic [AlphaW-1:0] alpha_m = 16'd6554;
  logic [31:0]       blocks_m = '0;
  logic [RmsW-1:0]   in_rms_m = '0, left_rms_m = '0, right_rms_m = '0;
  logic [AccW-1:0]   in_acc_m = '0, out_acc_m = '0;

  block_rms_ema_meter_top DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  function automatic logic [RmsW-1:0] lane_rms(logic [SumW-1:0] sum, logic [CntW-1:0] n);
    logic [31:0] r;
    if (n == 0 || sum == 0) return '0;
    r = int_sqrt(64'(sum) / 64'(n));
    return (r > 32'(RmsFull)) ? RmsFull : r[RmsW-1:0];
  endfunction

  function automatic logic [AccW-1:0] ema_step(logic [AccW-1:0] acc, logic [AccW-1:0] x);
    logic [63:0] t;
    t = 64'(acc) * (64'd65536 - 64'(alpha_m)) + 64'(x) * 64'(alpha_m) + 64'd32768;
    return t[47:16];
  endfunction

  function automatic meter_snap_t meter_predict(block_item_t it);
    meter_snap_t s;
    logic [AccW-1:0] x_in, x_out;
    logic [63:0] r_in, r_out;
    if (it.cmd == CmdClear) begin
      blocks_m = 0; in_rms_m = 0; left_rms_m = 0; right_rms_m = 0;
      in_acc_m = 0; out_acc_m = 0;
    end else begin
      in_rms_m = lane_rms(it.in_sq, it.count);
      left_rms_m = lane_rms(it.left_sq, it.count);
      right_rms_m = lane_rms(it.right_sq, it.count);
      x_in = 32'(in_rms_m) << 16;
      x_out = (32'(left_rms_m) + 32'(right_rms_m)) << 15;
      blocks_m = blocks_m + 1;
      if (blocks_m == 1) begin
        in_acc_m = x_in;
        out_acc_m = x_out;
      end
      in_acc_m = ema_step(in_acc_m, x_in);
      out_acc_m = ema_step(out_acc_m, x_out);
    end
    r_in = (64'(in_acc_m) + 64'd32768) >> 16;
    r_out = (64'(out_acc_m) + 64'd32768) >> 16;
    s.blocks = blocks_m;
    s.in_rms = in_rms_m;
    s.left_rms = left_rms_m;
    s.right_rms = right_rms_m;
    s.smooth_in = r_in[RmsW-1:0];
    s.smooth_out = r_out[RmsW-1:0];
    return s;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (!rst && (!in_valid || item_taken)) begin
      item_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        block_item_t it;
        it = pending_blocks.pop_front();
        cmd <= it.cmd;
        in_sum_sq <= it.in_sq;
        left_sum_sq <= it.left_sq;
        right_sum_sq <= it.right_sq;
        sample_count <= it.count;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure in bursts.
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: every transfer is sampled on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) alpha_m = cfg_data;
      if (in_valid && !in_stall) begin
        block_item_t it;
        it.cmd = cmd;
        it.in_sq = in_sum_sq;
        it.left_sq = left_sum_sq;
        it.right_sq = right_sum_sq;
        it.count = sample_count;
        expected_snaps.push_back(meter_predict(it));
        item_taken = 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_snaps.size() == 0) begin
          errors++;
          $display("%0t: result with no expected snapshot, actual count %0d", $time,
                   block_count);
        end else begin
          meter_snap_t s;
          s = expected_snaps.pop_front();
          check_field("block_count", s.blocks, block_count);
          check_field("last_in_rms", 32'(s.in_rms), 32'(last_in_rms));
          check_field("last_left_rms", 32'(s.left_rms), 32'(last_left_rms));
          check_field("last_right_rms", 32'(s.right_rms), 32'(last_right_rms));
          check_field("smooth_in_rms", 32'(s.smooth_in), 32'(smooth_in_rms));
          check_field("smooth_out_rms", 32'(s.smooth_out), 32'(smooth_out_rms));
        end
      end
    end
  end

  function automatic logic [SumW-1:0] rand_sum43();
    return SumW'({$urandom, $urandom});
  endfunction

  function automatic block_item_t rand_block();
    block_item_t it;
    logic [63:0] r, s;
    int kind;
    it.cmd = ($urandom_range(0, 11) == 0) ? CmdClear : CmdRecord;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // Arbitrary bit patterns, including counts above the block size.
      it.count = CntW'($urandom);
      it.in_sq = rand_sum43();
      it.left_sq = rand_sum43();
      it.right_sq = rand_sum43();
    end else begin
      it.count = (kind == 1) ? CntW'(0) : CntW'($urandom_range(1, 4096));
      r = 64'($urandom_range(0, 32768));
      s = 64'(it.count) * r * r;
      it.in_sq = s[SumW-1:0] + SumW'($urandom_range(0, 255));
      r = 64'($urandom_range(0, 32768));
      s = 64'(it.count) * r * r;
      it.left_sq = (kind == 2) ? '0 : s[SumW-1:0];
      r = 64'($urandom_range(0, 32768));
      s = 64'(it.count) * r * r;
      it.right_sq = s[SumW-1:0] + SumW'($urandom_range(0, 1023));
    end
    return it;
  endfunction

  task automatic add_block(logic c, logic [SumW-1:0] a, logic [SumW-1:0] l,
                           logic [SumW-1:0] r, logic [CntW-1:0] n);
    block_item_t it;
    it.cmd = c; it.in_sq = a; it.left_sq = l; it.right_sq = r; it.count = n;
    pending_blocks.push_back(it);
  endtask

  // Holds the stimulus back until the meter has answered everything.
  task automatic drain();
    while (pending_blocks.size() > 0 || in_valid || expected_snaps.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_alpha(logic [AlphaW-1:0] a);
    @(negedge clk);
    cfg_data <= a;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [AlphaW-1:0] alphas[5];
    alphas[0] = 16'd0;
    alphas[1] = 16'd65535;
    alphas[2] = AlphaW'($urandom);
    alphas[3] = 16'd1;
    alphas[4] = AlphaW'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part with the reset weight.
    add_block(CmdRecord, 43'd1000, 43'd4000, 43'd9000, 13'd1);
    add_block(CmdRecord, 43'd1 << 30, 43'd1 << 30, 43'd1 << 30, 13'd1);
    add_block(CmdRecord, SumMax, SumMax, SumMax, 13'd1);
    add_block(CmdRecord, 43'd4096 << 30, 43'd4096 << 30, 43'd0, 13'd4096);
    add_block(CmdRecord, SumMax, 43'd12345, 43'd1, 13'd0);
    add_block(CmdRecord, 43'd0, 43'd0, 43'd0, 13'd256);
    add_block(CmdRecord, SumMax, SumMax, 43'd8191, 13'd8191);
    add_block(CmdRecord, 43'd1, 43'd3, 43'd2, 13'd1);
    add_block(CmdClear, SumMax, SumMax, SumMax, 13'd8191);
    add_block(CmdRecord, 43'd500000, 43'd2000000, 43'd0, 13'd100);
    add_block(CmdRecord, 43'd12345678, 43'd87654321, 43'd5555555, 13'd4097);
    add_block(CmdClear, 43'd0, 43'd0, 43'd0, 13'd0);
    add_block(CmdClear, 43'd0, 43'd0, 43'd0, 13'd0);
    add_block(CmdRecord, 43'd5 << 30, 43'd3 << 30, 43'd7 << 29, 13'd6);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_alpha(alphas[ph]);
      if (ph == 4) quiet = 1;
      for (int i = 0; i < 350; i++) pending_blocks.push_back(rand_block());
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ block_rms_ema_meter_top.f @@
+incdir+hdl
hdl/brm_pkg.sv
hdl/brm_lane.sv
hdl/brm_merge.sv
hdl/block_rms_ema_meter_top.sv
test/tb.sv
